// File: rtl/core/gdc_pkg.sv
// gdc_pkg: types, constants and calendar tables for the date converter
package gdc_pkg;

  localparam int unsigned PIPE_DEPTH = 18;

  localparam logic [24:0] MAX_DAY_NUMBER = 25'd23936166;
  localparam int unsigned CYC400 = 146097;
  localparam int unsigned CYC100 = 36524;
  localparam int unsigned CYC4   = 1461;
  localparam int unsigned CYC1   = 365;

  // floor reciprocals; the quotient estimate is exact or one low
  localparam logic [9:0]  RECIP_100 = 10'((64'd1 << 16) / 100);
  localparam logic [7:0]  RECIP_400 = 8'((64'd1 << 25) / CYC400);
  localparam logic [5:0]  RECIP_4   = 6'((64'd1 << 16) / CYC4);
  localparam logic [22:0] RECIP_7   = 23'((64'd1 << 25) / 7);

  typedef enum logic [1:0] {
    OP_TO_NUMBER = 2'd0,
    OP_TO_DATE   = 2'd1,
    OP_ADD_DAYS  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DATE  = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         month;
    logic [4:0]         day;
    logic               y_zero;
    logic [15:0]        p;
    logic [24:0]        dn;
    logic signed [25:0] off;
    logic [25:0]        prod_p;
    logic [9:0]         q_p;
    logic [7:0]         rem_p;
    logic               leap_in;
    logic [24:0]        mul365;
    logic [24:0]        base;
    logic               date_ok;
    logic [8:0]         ms_in;
    logic [24:0]        n_date;
    logic signed [26:0] sum;
    err_e               err;
    logic [24:0]        n;
    logic [24:0]        r;
    logic [32:0]        prod400;
    logic [47:0]        prod7;
    logic [7:0]         q400;
    logic [18:0]        rem400;
    logic [3:0]         rem7;
    logic [1:0]         q100;
    logic [15:0]        r100;
    logic [20:0]        prod4;
    logic [4:0]         q4;
    logic [11:0]        rem4;
    logic [1:0]         q1;
    logic [8:0]         r1;
    logic [15:0]        year;
    logic               leap;
    logic [3:0]         month_out;
    logic [8:0]         ms_out;
    logic [4:0]         day_out;
    logic [2:0]         wd;
  } pipe_t;

  // days before the first of month idx (0 is january)
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    if (leap && idx >= 4'd2 && idx <= 4'd11) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

  // length of month m (1 is january)
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] v;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
      4'd2:                    v = leap ? 5'd29 : 5'd28;
      default:                 v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/gregorian_date_day_number_converter.sv
// gregorian_date_day_number_converter: pipelined proleptic gregorian date converter
// Converts a date to its day number (0001-01-01 is day 1), a day number to a date, or
// adds a signed day offset to a date, and gives leap flag, day number mod 7 and an error
// code with every result. The pipeline is 18 register stages deep, from the capture
// stage to the output register, and one request can enter every cycle unless a stalled
// output has filled it. Each stage has its own valid bit and advances when it is empty or
// the next stage moves, so a stalled output holds only the stages behind it and bubbles
// are squeezed out. Depth comes from the constant divisions (by 100, 146097, 1461 and 7),
// each done as a reciprocal multiply, a remainder multiply and a one-step correction in
// separate stages, followed by the month table search.
module gregorian_date_day_number_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic [24:0]        day_number_i,
  input  logic signed [25:0] day_offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [24:0]        result_day_number_o,
  output logic [15:0]        result_year_o,
  output logic [3:0]         result_month_o,
  output logic [4:0]         result_day_o,
  output logic               is_leap_o,
  output logic [2:0]         weekday_o,
  output logic [1:0]         error_o
);
  import gdc_pkg::*;

  localparam int unsigned NS = PIPE_DEPTH;

  pipe_t          st_d [NS];
  pipe_t          st_q [NS];
  logic  [NS-1:0] v_q;
  logic  [NS-1:0] v_in;
  logic  [NS-1:0] rdy;

  // per-stage handshake
  assign rdy[NS-1] = !v_q[NS-1] || out_ready_i;
  assign v_in[0]   = in_valid_i;
  for (genvar g = 0; g < NS - 1; g++) begin : g_flow
    assign rdy[g]    = !v_q[g] || rdy[g+1];
    assign v_in[g+1] = v_q[g];
  end

  assign in_ready_o = rdy[0];

  always_comb begin
    logic [15:0] t16;
    logic [9:0]  qc;
    logic [7:0]  rc;
    logic [24:0] nsel;
    err_e        esel;
    logic [24:0] t25;
    logic [17:0] r400;
    logic [1:0]  q100;
    logic [15:0] t16b;
    logic [1:0]  q1;
    logic [3:0]  idx;
    pipe_t       s;

    // stage 0: capture request
    s        = '0;
    s.op     = operation_i;
    s.month  = month_i;
    s.day    = day_i;
    s.y_zero = (year_i == 16'd0);
    s.p      = year_i - 16'd1;
    s.dn     = day_number_i;
    s.off    = day_offset_i;
    st_d[0]  = s;

    // stage 1: (year-1)/100 estimate
    s        = st_q[0];
    s.prod_p = 26'(s.p) * 26'(RECIP_100);
    st_d[1]  = s;

    // stage 2: remainder of the estimate
    s       = st_q[1];
    s.q_p   = s.prod_p[25:16];
    t16     = s.p - 16'(s.q_p) * 16'd100;
    s.rem_p = t16[7:0];
    st_d[2] = s;

    // stage 3: correct quotient, leap of the input year, 365 * (year-1)
    s  = st_q[2];
    qc = s.q_p;
    rc = s.rem_p;
    if (rc >= 8'd100) begin
      qc = qc + 10'd1;
      rc = rc - 8'd100;
    end
    s.q_p     = qc;
    s.rem_p   = rc;
    s.leap_in = (s.p[1:0] == 2'd3) && (rc != 8'd99 || qc[1:0] == 2'd3);
    s.mul365  = 25'(s.p) * 25'(CYC1);
    st_d[3]   = s;

    // stage 4: days before the year, date check, month start
    s         = st_q[3];
    s.base    = s.mul365 + 25'(s.p[15:2]) + 25'(s.q_p[9:2]) - 25'(s.q_p);
    s.date_ok = !s.y_zero && s.month != 4'd0 && s.month <= 4'd12 && s.day != 5'd0
                && s.day <= month_len(s.leap_in, s.month);
    s.ms_in   = month_start(s.leap_in, s.month - 4'd1);
    st_d[4]   = s;

    // stage 5: day number of the date
    s        = st_q[4];
    s.n_date = s.base + 25'(s.ms_in) + 25'(s.day);
    st_d[5]  = s;

    // stage 6: add the offset
    s       = st_q[5];
    s.sum   = $signed({2'b00, s.n_date}) + $signed({s.off[25], s.off});
    st_d[6] = s;

    // stage 7: pick the day number and the error
    s    = st_q[6];
    nsel = 25'd0;
    esel = ERR_NONE;
    unique case (s.op)
      OP_TO_NUMBER: begin
        if (s.date_ok) nsel = s.n_date;
        else           esel = ERR_DATE;
      end
      OP_TO_DATE: begin
        if (s.dn != 25'd0 && s.dn <= MAX_DAY_NUMBER) nsel = s.dn;
        else                                          esel = ERR_RANGE;
      end
      OP_ADD_DAYS: begin
        if (!s.date_ok) begin
          esel = ERR_DATE;
        end else if (s.sum >= 27'sd1 && s.sum <= $signed({2'b00, MAX_DAY_NUMBER})) begin
          nsel = s.sum[24:0];
        end else begin
          esel = ERR_RANGE;
        end
      end
      default: esel = ERR_DATE;
    endcase
    s.err   = esel;
    s.n     = nsel;
    s.r     = nsel - 25'd1;
    st_d[7] = s;

    // stage 8: estimates for the 400 year cycle and the weekday
    s         = st_q[7];
    s.prod400 = 33'(s.r) * 33'(RECIP_400);
    s.prod7   = 48'(s.n) * 48'(RECIP_7);
    st_d[8]   = s;

    // stage 9: remainders of both estimates
    s        = st_q[8];
    s.q400   = s.prod400[32:25];
    t25      = s.r - 25'(s.q400) * 25'(CYC400);
    s.rem400 = t25[18:0];
    t25      = s.n - 25'(s.prod7[47:25]) * 25'd7;
    s.rem7   = t25[3:0];
    st_d[9]  = s;

    // stage 10: correct both
    s = st_q[9];
    if (s.rem400 >= 19'(CYC400)) begin
      s.q400   = s.q400 + 8'd1;
      s.rem400 = s.rem400 - 19'(CYC400);
    end
    if (s.rem7 >= 4'd7) begin
      s.wd = 3'(s.rem7 - 4'd7);
    end else begin
      s.wd = s.rem7[2:0];
    end
    st_d[10] = s;

    // stage 11: century within the cycle, last one absorbs the extra day
    s    = st_q[10];
    r400 = s.rem400[17:0];
    q100 = 2'(r400 >= 18'(CYC100)) + 2'(r400 >= 18'(2 * CYC100))
         + 2'(r400 >= 18'(3 * CYC100));
    s.q100   = q100;
    s.r100   = 16'(r400 - 18'(q100) * 18'(CYC100));
    st_d[11] = s;

    // stage 12: 4 year cycle estimate
    s        = st_q[11];
    s.prod4  = 21'(s.r100) * 21'(RECIP_4);
    st_d[12] = s;

    // stage 13: its remainder
    s        = st_q[12];
    s.q4     = s.prod4[20:16];
    t16b     = s.r100 - 16'(s.q4) * 16'(CYC4);
    s.rem4   = t16b[11:0];
    st_d[13] = s;

    // stage 14: correct
    s = st_q[13];
    if (s.rem4 >= 12'(CYC4)) begin
      s.q4   = s.q4 + 5'd1;
      s.rem4 = s.rem4 - 12'(CYC4);
    end
    st_d[14] = s;

    // stage 15: year within the 4 year cycle, leap year last
    s  = st_q[14];
    q1 = 2'(s.rem4 >= 12'(CYC1)) + 2'(s.rem4 >= 12'(2 * CYC1))
       + 2'(s.rem4 >= 12'(3 * CYC1));
    s.q1     = q1;
    s.r1     = 9'(s.rem4 - 12'(q1) * 12'(CYC1));
    st_d[15] = s;

    // stage 16: year, leap flag, month search
    s      = st_q[15];
    s.year = 16'(s.q400) * 16'd400 + 16'(s.q100) * 16'd100 + 16'(s.q4) * 16'd4
           + 16'(s.q1) + 16'd1;
    s.leap = (s.q1 == 2'd3) && (s.q4 != 5'd24 || s.q100 == 2'd3);
    idx    = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (month_start(s.leap, 4'(k)) <= s.r1) begin
        idx = 4'(k);
      end
    end
    s.month_out = idx + 4'd1;
    s.ms_out    = month_start(s.leap, idx);
    st_d[16]    = s;

    // stage 17: day of month, clear all results but the error code on error
    s         = st_q[16];
    s.day_out = 5'(s.r1 - s.ms_out + 9'd1);
    if (s.err != ERR_NONE) begin
      s.n         = 25'd0;
      s.year      = 16'd0;
      s.month_out = 4'd0;
      s.day_out   = 5'd0;
      s.leap      = 1'b0;
      s.wd        = 3'd0;
    end
    st_d[17] = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NS; i++) begin
      if (rdy[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign out_valid_o         = v_q[NS-1];
  assign result_day_number_o = st_q[NS-1].n;
  assign result_year_o       = st_q[NS-1].year;
  assign result_month_o      = st_q[NS-1].month_out;
  assign result_day_o        = st_q[NS-1].day_out;
  assign is_leap_o           = st_q[NS-1].leap;
  assign weekday_o           = st_q[NS-1].wd;
  assign error_o             = st_q[NS-1].err;

endmodule
